// ===== rtl/assert_macros.svh =====
// assertion helpers, clocked and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/isp_pkg.sv =====
`default_nettype none

package isp_pkg;

    localparam int MAX_DEPTH     = 64;
    localparam int DEPTH_DEFAULT = 64;
    localparam int VAL_W         = 32;
    localparam int CNT_W         = $clog2(MAX_DEPTH + 1);

    typedef struct packed {
        logic             insert;
        logic             shift;
        logic [CNT_W-1:0] count;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== rtl/integer_list_sorter_top.sv =====
// channel   | handshake              | payload
// ----------+------------------------+---------------------------------------
// input     | start / busy           | i_value (32b signed), i_last
// result    | o_strobe (one cycle)   | o_sorted_value (32b signed), o_final_res, o_dropped
//
// one element loads per cycle while not busy; a sorted insertion chain places each on arrival
// n kept elements come out as n results once emitting begins after the last item's transfer
// busy is high while emitting; the next item may be taken in the cycle of the final transfer
// synchronous active-low reset empties the list; no clearing pass is needed
// the receiver cannot stall, each result is valid for the single cycle of its strobe
`default_nettype none

module integer_list_sorter_top #(
    parameter int DEPTH = isp_pkg::DEPTH_DEFAULT
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire logic signed [isp_pkg::VAL_W-1:0] i_value,
    input  wire                                   i_last,
    output logic                                  o_strobe,
    output logic signed [isp_pkg::VAL_W-1:0]      o_sorted_value,
    output logic                                  o_final_res,
    output logic                                  o_dropped
);

    isp_pkg::t_dp_cmd w_cmd;

    isp_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_last      (i_last),
        .busy        (busy),
        .o_cmd       (w_cmd),
        .o_strobe    (o_strobe),
        .o_final_res (o_final_res),
        .o_dropped   (o_dropped)
    );

    isp_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_value        (i_value),
        .o_sorted_value (o_sorted_value)
    );

endmodule

`default_nettype wire

// ===== rtl/isp_dpath.sv =====
`default_nettype none

module isp_dpath #(
    parameter int DEPTH = isp_pkg::DEPTH_DEFAULT
) (
    input  wire                                i_clk,
    input  wire isp_pkg::t_dp_cmd              i_cmd,
    input  wire logic signed [isp_pkg::VAL_W-1:0] i_value,
    output logic signed [isp_pkg::VAL_W-1:0]   o_sorted_value
);

    logic signed [isp_pkg::VAL_W-1:0] r_cell [DEPTH];
    logic signed [isp_pkg::VAL_W-1:0] r_out;
    logic [DEPTH-1:0]                 w_after;

    // insertion point: first occupied cell holding a larger value, or first free cell
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_after[i] = (isp_pkg::CNT_W'(i) >= i_cmd.count) || (i_value < r_cell[i]);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [isp_pkg::VAL_W-1:0] w_prev;
        logic signed [isp_pkg::VAL_W-1:0] w_next;
        logic                             w_prev_after;

        if (g == 0) begin : g_head
            assign w_prev       = i_value;
            assign w_prev_after = 1'b0;
        end else begin : g_body
            assign w_prev       = r_cell[g-1];
            assign w_prev_after = w_after[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next = r_cell[g];
        end else begin : g_mid
            assign w_next = r_cell[g+1];
        end

        // emit shifts toward the head, insert opens a gap and shifts toward the tail
        always_ff @(posedge i_clk) begin
            if (i_cmd.shift) begin
                r_cell[g] <= w_next;
            end else if (i_cmd.insert && w_after[g]) begin
                r_cell[g] <= w_prev_after ? w_prev : i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_out <= r_cell[0];
        end
    end

    assign o_sorted_value = r_out;

endmodule

`default_nettype wire

// ===== rtl/isp_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

module isp_ctrl #(
    parameter int DEPTH = isp_pkg::DEPTH_DEFAULT
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    input  wire              i_last,
    output logic             busy,
    output isp_pkg::t_dp_cmd o_cmd,
    output logic             o_strobe,
    output logic             o_final_res,
    output logic             o_dropped
);

    typedef enum logic {
        S_LOAD,
        S_EMIT
    } t_state;

    localparam logic [isp_pkg::CNT_W-1:0] FULL = isp_pkg::CNT_W'(DEPTH);

    t_state                    r_state;
    logic [isp_pkg::CNT_W-1:0] r_count;
    logic [isp_pkg::CNT_W-1:0] r_remaining;
    logic                      r_overflow;
    logic                      r_strobe;
    logic                      r_final;
    logic                      r_dropped;

    logic                      w_accept;
    logic                      w_room;
    logic                      w_last_out;
    logic [isp_pkg::CNT_W-1:0] n_count;
    logic                      n_overflow;

    assign busy       = (r_state == S_EMIT);
    assign w_accept   = start && !busy;
    assign w_room     = (r_count < FULL);
    assign w_last_out = (r_remaining == isp_pkg::CNT_W'(1));

    assign n_count    = w_room ? r_count + isp_pkg::CNT_W'(1) : r_count;
    assign n_overflow = r_overflow || !w_room;

    assign o_cmd.insert = w_accept && w_room;
    assign o_cmd.shift  = busy;
    assign o_cmd.count  = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_remaining <= '0;
            r_overflow  <= 1'b0;
            r_strobe    <= 1'b0;
            r_final     <= 1'b0;
            r_dropped   <= 1'b0;
        end else begin
            r_strobe  <= 1'b0;
            r_final   <= 1'b0;
            r_dropped <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        r_count    <= n_count;
                        r_overflow <= n_overflow;
                        if (i_last) begin
                            r_remaining <= n_count;
                            r_state     <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    r_strobe    <= 1'b1;
                    r_final     <= w_last_out;
                    r_dropped   <= w_last_out && r_overflow;
                    r_remaining <= r_remaining - isp_pkg::CNT_W'(1);
                    if (w_last_out) begin
                        r_count    <= '0;
                        r_overflow <= 1'b0;
                        r_state    <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_strobe    = r_strobe;
    assign o_final_res = r_final;
    assign o_dropped   = r_dropped;

    `ASSERT_PROP(a_final_ends_emit, i_clk, i_rst_n, (r_strobe && r_final) |-> (r_state == S_LOAD), "final transfer while still emitting")
    `ASSERT_PROP(a_dropped_on_final, i_clk, i_rst_n, r_dropped |-> (r_final && r_strobe), "dropped flag outside final transfer")
    `ASSERT_PROP(a_count_bound, i_clk, i_rst_n, r_count <= FULL, "element count beyond depth")
    `ASSERT_NEVER(a_emit_nonempty, i_clk, i_rst_n, (r_state == S_EMIT) && (r_remaining == '0), "emitting with nothing left")

endmodule

`default_nettype wire
